FILE: rtl/ihmp_pkg.sv
`timescale 1ns / 1ps

package ihmp_pkg;

   // Defaults for the top-level parameters
   localparam int DEFAULT_MAX_HEADER_BYTES = 1024;
   localparam int DEFAULT_MAX_LINE         = 96;

   // Fixed field widths
   localparam int IMAGE_SIZE_W  = 32;
   localparam int BODY_START_W  = 11;
   localparam int DIGEST_HALF_W = 64;
   localparam int DIGEST_W      = 2 * DIGEST_HALF_W;

   // Command codes on the request channel
   typedef enum logic [1:0] {
      CMD_BYTE    = 2'd0,
      CMD_STOP    = 2'd1,
      CMD_RESTART = 2'd2
   } command_type;

   // Result status codes
   localparam logic [1:0] STATUS_PARSING = 2'd0;
   localparam logic [1:0] STATUS_DONE    = 2'd1;
   localparam logic [1:0] STATUS_FAIL    = 2'd2;

   // Parse phase
   typedef enum logic [2:0] {
      PH_PARSING = 3'b001,
      PH_DONE    = 3'b010,
      PH_FAIL    = 3'b100
   } phase_type;

   // Prefix matcher: 0..4 = chars matched, then these two
   localparam logic [2:0] PREFIX_EMPTY   = 3'd0;
   localparam logic [2:0] PREFIX_MATCHED = 3'd5;
   localparam logic [2:0] PREFIX_MISS    = 3'd6;

   // Terminator line matcher
   localparam logic [1:0] DASH_EMPTY = 2'd0;
   localparam logic [1:0] DASH_ONE   = 2'd1;
   localparam logic [1:0] DASH_TWO   = 2'd2;
   localparam logic [1:0] DASH_OTHER = 2'd3;

   localparam logic [5:0] HEX_COUNT_FULL = 6'd32;
   localparam logic [5:0] HEX_COUNT_SAT  = 6'd33;

   localparam logic [7:0] CHAR_NUL  = 8'h00;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_DASH = 8'h2D;

   // Per-line text tracking
   typedef struct packed {
      logic [2:0]          prefix_state;
      logic [1:0]          dash_state;
      logic [5:0]          hex_count;
      logic                hex_bad;
      logic [DIGEST_W-1:0] digit_shift;
   } line_text_type;

   // "MD5: "
   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h4D;
         3'd1: c = 8'h44;
         3'd2: c = 8'h35;
         3'd3: c = 8'h3A;
         3'd4: c = 8'h20;
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   // {valid, nibble}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

FILE: rtl/ihmp_char_scan.sv
`timescale 1ns / 1ps

// Advances the line matchers by one text character.
module ihmp_char_scan (
   input  logic [7:0]              char_byte,
   input  ihmp_pkg::line_text_type line_cur,
   output ihmp_pkg::line_text_type line_next
);
   import ihmp_pkg::*;

   logic [4:0] hex;

   assign hex = hex_digit(char_byte);

   always_comb begin
      line_next = line_cur;

      if (line_cur.dash_state == DASH_EMPTY && char_byte == CHAR_DASH) begin
         line_next.dash_state = DASH_ONE;
      end else if (line_cur.dash_state == DASH_ONE && char_byte == CHAR_DASH) begin
         line_next.dash_state = DASH_TWO;
      end else begin
         line_next.dash_state = DASH_OTHER;
      end

      if (line_cur.prefix_state < PREFIX_MATCHED) begin
         line_next.prefix_state = (char_byte == prefix_char(line_cur.prefix_state)) ?
                                  line_cur.prefix_state + 3'd1 : PREFIX_MISS;
      end else if (line_cur.prefix_state == PREFIX_MATCHED) begin
         if (!hex[4]) begin
            line_next.hex_bad = 1'b1;
         end
         if (line_cur.hex_count < HEX_COUNT_FULL && hex[4]) begin
            line_next.digit_shift = {line_cur.digit_shift[DIGEST_W-5:0], hex[3:0]};
         end
         if (line_cur.hex_count < HEX_COUNT_SAT) begin
            line_next.hex_count = line_cur.hex_count + 6'd1;
         end
      end
   end

endmodule

FILE: rtl/image_header_md5_parser.sv
`timescale 1ns / 1ps
// Latency: a result beat appears the cycle after its request beat is taken.
// Throughput: one request beat per cycle; intake stalls only in a cycle where
//   a result is parked in the output register and the receiver is stalling.
// Reset (synchronous, active high) clears image_size, the parse phase and all
//   line and header tracking; digest and offset holders are gated by phase.
module image_header_md5_parser #(
   parameter int MAX_HEADER_BYTES = ihmp_pkg::DEFAULT_MAX_HEADER_BYTES,
   parameter int MAX_LINE         = ihmp_pkg::DEFAULT_MAX_LINE
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_wr_en,
   input  logic [ihmp_pkg::IMAGE_SIZE_W-1:0]      csr_wr_data,
   // request beats
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_command,
   input  logic [7:0]                             req_data_byte,
   // result beats
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [1:0]                             rsp_status,
   output logic [ihmp_pkg::BODY_START_W-1:0]      rsp_body_start,
   output logic [ihmp_pkg::IMAGE_SIZE_W-1:0]      rsp_body_len,
   output logic [ihmp_pkg::DIGEST_HALF_W-1:0]     rsp_digest_high,
   output logic [ihmp_pkg::DIGEST_HALF_W-1:0]     rsp_digest_low
);
   import ihmp_pkg::*;

   // header_count never passes MAX_HEADER_BYTES; line_len stays below MAX_LINE
   localparam int HCW = $clog2(MAX_HEADER_BYTES + 1);
   localparam int LLW = $clog2(MAX_LINE);

   localparam line_text_type LINE_CLEAR = '{
      prefix_state: PREFIX_EMPTY,
      dash_state:   DASH_EMPTY,
      hex_count:    6'd0,
      hex_bad:      1'b0,
      digit_shift:  '0
   };

   // ---------------- state ----------------
   logic [IMAGE_SIZE_W-1:0] image_size_ff;
   phase_type               phase_ff, phase_in;
   logic [HCW-1:0]          header_count_ff, header_count_in;
   logic [LLW-1:0]          line_len_ff, line_len_in;
   logic                    text_ended_ff, text_ended_in;
   line_text_type           line_ff, line_in, line_scan;
   logic                    has_digest_ff, has_digest_in;
   logic [DIGEST_W-1:0]     digest_ff, digest_in;
   logic [HCW-1:0]          body_start_ff, body_start_in;
   logic [IMAGE_SIZE_W-1:0] body_len_ff, body_len_in;

   // ---------------- result register ----------------
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [BODY_START_W-1:0] rsp_body_start_ff, rsp_body_start_in;
   logic [IMAGE_SIZE_W-1:0] rsp_body_len_ff, rsp_body_len_in;
   logic [DIGEST_W-1:0]     rsp_digest_ff, rsp_digest_in;

   logic                    accept;
   logic [IMAGE_SIZE_W-1:0] count_wide;
   logic [HCW+BODY_START_W-1:0] offset_wide;

   // Intake stalls only when a result is parked and the far side is stalling.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   ihmp_char_scan u_char_scan (
      .char_byte (req_data_byte),
      .line_cur  (line_ff),
      .line_next (line_scan)
   );

   // byte count including the byte now arriving
   assign count_wide = IMAGE_SIZE_W'(header_count_ff) + IMAGE_SIZE_W'(1);

   // ---------------- per-beat next state ----------------
   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      line_len_in     = line_len_ff;
      text_ended_in   = text_ended_ff;
      line_in         = line_ff;
      has_digest_in   = has_digest_ff;
      digest_in       = digest_ff;
      body_start_in   = body_start_ff;
      body_len_in     = body_len_ff;

      case (req_command)
         CMD_RESTART: begin
            phase_in        = PH_PARSING;
            header_count_in = '0;
            line_len_in     = '0;
            text_ended_in   = 1'b0;
            line_in         = LINE_CLEAR;
            has_digest_in   = 1'b0;
         end
         CMD_STOP: begin
            if (phase_ff == PH_PARSING) begin
               phase_in = PH_FAIL;
            end
         end
         CMD_BYTE: begin
            if (phase_ff == PH_PARSING) begin
               header_count_in = header_count_ff + HCW'(1);
               if (req_data_byte == CHAR_LF) begin
                  if (line_ff.dash_state == DASH_TWO) begin
                     // terminator line: body must be nonempty and a digest seen
                     if (image_size_ff <= count_wide || !has_digest_ff) begin
                        phase_in = PH_FAIL;
                     end else begin
                        phase_in      = PH_DONE;
                        body_start_in = header_count_in;
                        body_len_in   = image_size_ff - count_wide;
                     end
                  end else if (line_ff.prefix_state == PREFIX_MATCHED &&
                               (has_digest_ff || line_ff.hex_bad ||
                                line_ff.hex_count != HEX_COUNT_FULL)) begin
                     phase_in = PH_FAIL;
                  end else begin
                     if (line_ff.prefix_state == PREFIX_MATCHED) begin
                        digest_in     = line_ff.digit_shift;
                        has_digest_in = 1'b1;
                     end
                     line_len_in   = '0;
                     text_ended_in = 1'b0;
                     line_in       = LINE_CLEAR;
                  end
               end else if (line_len_ff >= LLW'(MAX_LINE - 1)) begin
                  // line too long, carriage return included
                  phase_in = PH_FAIL;
               end else if (req_data_byte != CHAR_CR) begin
                  line_len_in = line_len_ff + LLW'(1);
                  if (!text_ended_ff) begin
                     if (req_data_byte == CHAR_NUL) begin
                        text_ended_in = 1'b1;
                     end else begin
                        line_in = line_scan;
                     end
                  end
               end
               if (phase_in == PH_PARSING && header_count_in >= HCW'(MAX_HEADER_BYTES)) begin
                  phase_in = PH_FAIL;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------- result beat ----------------
   assign offset_wide = {{BODY_START_W{1'b0}}, body_start_in};

   always_comb begin
      rsp_status_in     = STATUS_PARSING;
      rsp_body_start_in = '0;
      rsp_body_len_in   = '0;
      rsp_digest_in     = '0;
      case (phase_in)
         PH_DONE: begin
            rsp_status_in     = STATUS_DONE;
            rsp_body_start_in = offset_wide[BODY_START_W-1:0];
            rsp_body_len_in   = body_len_in;
            rsp_digest_in     = digest_in;
         end
         PH_FAIL: begin
            rsp_status_in = STATUS_FAIL;
         end
         default: begin
            rsp_status_in = STATUS_PARSING;
         end
      endcase

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff   <= '0;
         phase_ff        <= PH_PARSING;
         header_count_ff <= '0;
         line_len_ff     <= '0;
         text_ended_ff   <= 1'b0;
         line_ff         <= LINE_CLEAR;
         has_digest_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            image_size_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff        <= phase_in;
            header_count_ff <= header_count_in;
            line_len_ff     <= line_len_in;
            text_ended_ff   <= text_ended_in;
            line_ff         <= line_in;
            has_digest_ff   <= has_digest_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         digest_ff         <= digest_in;
         body_start_ff     <= body_start_in;
         body_len_ff       <= body_len_in;
         rsp_status_ff     <= rsp_status_in;
         rsp_body_start_ff <= rsp_body_start_in;
         rsp_body_len_ff   <= rsp_body_len_in;
         rsp_digest_ff     <= rsp_digest_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_body_start  = rsp_body_start_ff;
   assign rsp_body_len    = rsp_body_len_ff;
   assign rsp_digest_high = rsp_digest_ff[DIGEST_W-1:DIGEST_HALF_W];
   assign rsp_digest_low  = rsp_digest_ff[DIGEST_HALF_W-1:0];

`ifndef SYNTHESIS
   // a done result never carries an empty body
   a_done_body_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_DONE |-> rsp_body_len != '0)
      else $error("done result with zero body size");

   // the byte counter fails the header before running past the limit
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      header_count_ff <= HCW'(MAX_HEADER_BYTES))
      else $error("header count past limit");

   // rejected stays rejected until a restart
   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_FAIL && req_command != CMD_RESTART
      |=> rsp_valid && rsp_status == STATUS_FAIL)
      else $error("rejected header left fail state");
`endif

endmodule
